### hw/rtl/linear_search_key_value_table_macros.svh
// Assertion macros for the key/value table RTL (used by lskv_seq).
// Depends on nothing; users must have clk and rst (active-high) in scope.
`ifndef LINEAR_SEARCH_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_SEARCH_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define LSKV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lskv assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define LSKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lskv assertion failed");

`endif

### hw/rtl/lskv_pkg.sv
// Shared types and codes for the linear-search key/value table.
// No dependencies.
package lskv_pkg;

  typedef enum logic [1:0] {
    ACT_PUT      = 2'd0,
    ACT_GET      = 2'd1,
    ACT_REMOVE   = 2'd2,
    ACT_READ_POS = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Write strobes from the sequencer to the table storage.
  typedef struct packed {
    logic wr_key;
    logic wr_value;
  } mem_cmd_t;

  // Result handoff from the sequencer to the output register.
  typedef struct packed {
    logic    push;
    logic    found;
    status_t status;
  } res_ctl_t;

endpackage

### hw/rtl/lskv_mem.sv
// Key and value storage: one write port, one registered read port.
// Depends on lskv_pkg (mem_cmd_t).
module lskv_mem #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  lskv_pkg::mem_cmd_t          cmd,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr,
  input  logic [KEY_BITS-1:0]         wr_key,
  input  logic [VALUE_BITS-1:0]       wr_value,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr,
  output logic [KEY_BITS-1:0]         rd_key,
  output logic [VALUE_BITS-1:0]       rd_value
);

  logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
  logic [VALUE_BITS-1:0] value_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (cmd.wr_key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (cmd.wr_value) begin
      value_mem[wr_addr] <= wr_value;
    end
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

### hw/rtl/lskv_seq.sv
// Sequencer: scans the table one slot per cycle through the shared key
// comparator and performs put/get/remove/read. Depends on lskv_pkg and macros.
`include "linear_search_key_value_table_macros.svh"

module lskv_seq #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [KEY_BITS-1:0]              key,
  input  logic [VALUE_BITS-1:0]            value,
  input  logic [$clog2(CAPACITY)-1:0]      position,
  input  logic                             out_free,
  output lskv_pkg::res_ctl_t               res_ctl,
  output logic [KEY_BITS-1:0]              res_key,
  output logic [VALUE_BITS-1:0]            res_value,
  output logic [$clog2(CAPACITY+1)-1:0]    res_total,
  output lskv_pkg::mem_cmd_t               mem_cmd,
  output logic [$clog2(CAPACITY)-1:0]      mem_wr_addr,
  output logic [KEY_BITS-1:0]              mem_wr_key,
  output logic [VALUE_BITS-1:0]            mem_wr_value,
  output logic [$clog2(CAPACITY)-1:0]      mem_rd_addr,
  input  logic [KEY_BITS-1:0]              mem_rd_key,
  input  logic [VALUE_BITS-1:0]            mem_rd_value
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MV_RD,
    S_MV_WR,
    S_POS_RD,
    S_POS_WR,
    S_FIN
  } state_t;

  state_t                state;
  lskv_pkg::action_t     act;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;
  logic [AW-1:0]         req_pos;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic                  pend;
  logic [AW-1:0]         pend_addr;
  logic [AW-1:0]         hit_slot;
  lskv_pkg::status_t     status;
  logic                  found;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;

  logic hit;
  logic scan_end;
  logic has_room;

  // pend marks that the read data belongs to slot pend_addr
  assign hit      = pend && (mem_rd_key == req_key);
  assign scan_end = (idx >= count);
  assign has_room = (count < CW'(CAPACITY));

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act       <= lskv_pkg::action_t'(action);
            req_key   <= key;
            req_value <= value;
            req_pos   <= position;
            status    <= lskv_pkg::ST_OK;
            found     <= 1'b0;
            rkey      <= '0;
            rval      <= '0;
            idx       <= '0;
            pend      <= 1'b0;
            if (lskv_pkg::action_t'(action) == lskv_pkg::ACT_READ_POS) begin
              state <= S_POS_RD;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            pend  <= 1'b0;
            unique case (act)
              lskv_pkg::ACT_GET: begin
                rval  <= mem_rd_value;
                state <= S_FIN;
              end
              lskv_pkg::ACT_REMOVE: begin
                rval     <= mem_rd_value;
                hit_slot <= pend_addr;
                count    <= count - CW'(1);
                state    <= S_MV_RD;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end else if (scan_end) begin
            pend <= 1'b0;
            if (act == lskv_pkg::ACT_PUT) begin
              if (has_room) begin
                count <= count + CW'(1);
              end else begin
                status <= lskv_pkg::ST_FULL;
              end
            end else begin
              status <= lskv_pkg::ST_MISS;
            end
            state <= S_FIN;
          end else begin
            pend      <= 1'b1;
            pend_addr <= idx[AW-1:0];
            idx       <= idx + CW'(1);
          end
        end
        S_MV_RD: begin
          state <= S_MV_WR;
        end
        S_MV_WR: begin
          state <= S_FIN;
        end
        S_POS_RD: begin
          if (CW'(req_pos) < count) begin
            state <= S_POS_WR;
          end else begin
            status <= lskv_pkg::ST_RANGE;
            state  <= S_FIN;
          end
        end
        S_POS_WR: begin
          found <= 1'b1;
          rkey  <= mem_rd_key;
          rval  <= mem_rd_value;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // storage port steering
  always_comb begin
    mem_cmd      = '0;
    mem_wr_addr  = pend_addr;
    mem_wr_key   = req_key;
    mem_wr_value = req_value;
    mem_rd_addr  = idx[AW-1:0];
    unique case (state)
      S_SCAN: begin
        if (hit && act == lskv_pkg::ACT_PUT) begin
          mem_cmd.wr_value = 1'b1;
        end else if (!hit && scan_end && act == lskv_pkg::ACT_PUT && has_room) begin
          mem_cmd.wr_key   = 1'b1;
          mem_cmd.wr_value = 1'b1;
          mem_wr_addr      = count[AW-1:0];
        end
      end
      S_MV_RD: begin
        mem_rd_addr = count[AW-1:0];
      end
      S_MV_WR: begin
        mem_cmd.wr_key   = 1'b1;
        mem_cmd.wr_value = 1'b1;
        mem_wr_addr      = hit_slot;
        mem_wr_key       = mem_rd_key;
        mem_wr_value     = mem_rd_value;
      end
      S_POS_RD: begin
        mem_rd_addr = req_pos;
      end
      default: begin
      end
    endcase
  end

  assign res_ctl.push   = (state == S_FIN) && out_free;
  assign res_ctl.found  = found;
  assign res_ctl.status = status;
  assign res_key        = rkey;
  assign res_value      = rval;
  assign res_total      = count;

  `LSKV_ASSERT_IMPL(a_count_max, 1'b1, count <= CW'(CAPACITY))
  `LSKV_ASSERT_IMPL(a_wr_in_range, mem_cmd.wr_key, CW'(mem_wr_addr) <= count)
  `LSKV_ASSERT_NEXT(a_rm_shrinks, state == S_SCAN && hit && act == lskv_pkg::ACT_REMOVE,
                    count == $past(count) - CW'(1))
  `LSKV_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state != S_IDLE)

endmodule

### hw/rtl/linear_search_key_value_table.sv
// Top level of the linear-search key/value table: sequencer, storage and
// output register. Depends on lskv_pkg, lskv_mem and lskv_seq.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | action, key, value, position
//  out     | out_valid / out_stall| status, found, result_key, result_value,
//          |                      | entry_total
//
// Search compares one slot per cycle.
// One transaction at a time; the output register lets the next transaction
//   enter while the previous result waits on out_stall.
// Reset (rst, synchronous) empties the table; storage contents are not cleared.
module linear_search_key_value_table #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [KEY_BITS-1:0]           key,
  input  logic [VALUE_BITS-1:0]         value,
  input  logic [$clog2(CAPACITY)-1:0]   position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [KEY_BITS-1:0]           result_key,
  output logic [VALUE_BITS-1:0]         result_value,
  output logic [$clog2(CAPACITY+1)-1:0] entry_total
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  lskv_pkg::res_ctl_t    res_ctl;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;
  logic [CW-1:0]         res_total;
  lskv_pkg::mem_cmd_t    mem_cmd;
  logic [AW-1:0]         mem_wr_addr;
  logic [KEY_BITS-1:0]   mem_wr_key;
  logic [VALUE_BITS-1:0] mem_wr_value;
  logic [AW-1:0]         mem_rd_addr;
  logic [KEY_BITS-1:0]   mem_rd_key;
  logic [VALUE_BITS-1:0] mem_rd_value;
  logic                  out_free;

  // output slot is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  lskv_seq #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .key          (key),
    .value        (value),
    .position     (position),
    .out_free     (out_free),
    .res_ctl      (res_ctl),
    .res_key      (res_key),
    .res_value    (res_value),
    .res_total    (res_total),
    .mem_cmd      (mem_cmd),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_key   (mem_wr_key),
    .mem_wr_value (mem_wr_value),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_key   (mem_rd_key),
    .mem_rd_value (mem_rd_value)
  );

  lskv_mem #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_mem (
    .clk      (clk),
    .cmd      (mem_cmd),
    .wr_addr  (mem_wr_addr),
    .wr_key   (mem_wr_key),
    .wr_value (mem_wr_value),
    .rd_addr  (mem_rd_addr),
    .rd_key   (mem_rd_key),
    .rd_value (mem_rd_value)
  );

  // output register: holds a finished result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ctl.push) begin
      out_valid    <= 1'b1;
      status       <= res_ctl.status;
      found        <= res_ctl.found;
      result_key   <= res_key;
      result_value <= res_value;
      entry_total  <= res_total;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
